FILE: rtl/dpps_pkg.sv
// Shared types and constants for the dynamic priority process scheduler.
// No dependencies; imported by dpps_ctrl and the top level.
`default_nettype none

package dpps_pkg;

    localparam int TAG_W   = 8;
    localparam int PRIO_W  = 10;
    localparam int TIME_W  = 8;
    localparam int OCC_W   = 5;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    localparam logic signed [PRIO_W-1:0] PRIO_MIN = -10'sd512;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_SHIFT,
        S_FIN,
        S_DONE
    } t_state;

    // One stored table entry.
    typedef struct packed {
        logic [TAG_W-1:0]         tag;
        logic signed [PRIO_W-1:0] prio;
        logic [TIME_W-1:0]        need;
        logic [TIME_W-1:0]        elapsed;
    } t_entry;

    typedef struct packed {
        t_op                op;
        logic [TAG_W-1:0]   tag;
        logic signed [7:0]  prio;
        logic [TIME_W-1:0]  need;
    } t_request;

    typedef struct packed {
        logic [OCC_W-1:0]         occupancy;
        logic                     table_empty;
        logic                     finished;
        logic [TIME_W-1:0]        run_elapsed;
        logic signed [PRIO_W-1:0] run_priority;
        logic [TAG_W-1:0]         run_tag;
        logic                     accepted;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/dpps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dpps_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/dpps_ctrl.sv
// Sequencer and shared compare unit: scans the table, compacts it, re-appends.
// Depends on dpps_pkg; drives the ports of one dpps_ram.
`default_nettype none

module dpps_ctrl
    import dpps_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_req_valid,
    input  wire t_request                       i_req,
    output      logic                           o_req_ready,
    output      logic                           o_res_valid,
    output      t_result                        o_res,
    input  wire logic                           i_res_ready,
    output      logic                           o_we,
    output      logic [$clog2(MAX_ENTRIES)-1:0] o_waddr,
    output      t_entry                         o_wdata,
    output      logic [$clog2(MAX_ENTRIES)-1:0] o_raddr,
    input  wire t_entry                         i_rdata
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ENTRIES);

    t_state          r_state, n_state;
    t_request        r_req;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_idx;
    logic [CW-1:0]   r_ridx;
    logic            r_rvalid;
    t_entry          r_best;
    logic [CW-1:0]   r_best_pos;
    t_result         r_res;

    logic                     take;
    logic                     scan_last;
    logic                     shift_done;
    logic [CW-1:0]            pos_sel;
    logic [TIME_W-1:0]        el_next;
    logic                     fin_now;
    logic signed [PRIO_W-1:0] prio_next;
    logic [CW-1:0]            cnt_after;
    logic [CW-1:0]            cnt_add;
    t_result                  exec_res;
    t_result                  fin_res;

    // compare unit, shared across all entries of the scan
    assign take = r_rvalid && ((r_ridx == '0) || (i_rdata.prio > r_best.prio));
    assign scan_last  = r_rvalid && (r_ridx == r_count - 1'b1);
    assign shift_done = (r_idx >= r_count) && !r_rvalid;
    assign pos_sel    = take ? r_ridx : r_best_pos;

    assign el_next   = r_best.elapsed + 1'b1;
    assign fin_now   = (el_next >= r_best.need);
    assign prio_next = (r_best.prio == PRIO_MIN) ? r_best.prio : r_best.prio - 10'sd1;
    assign cnt_after = fin_now ? r_count - 1'b1 : r_count;
    assign cnt_add   = r_count + 1'b1;

    // result words for an add or empty tick, and for a dispatched tick
    always_comb begin
        exec_res             = '0;
        exec_res.occupancy   = OCC_W'(r_count);
        exec_res.table_empty = (r_count == '0);
        if (r_req.op == OP_ADD) begin
            exec_res.table_empty = 1'b0;
            if (r_count < CNT_MAX) begin
                exec_res.accepted  = 1'b1;
                exec_res.occupancy = OCC_W'(cnt_add);
            end
        end

        fin_res              = '0;
        fin_res.accepted     = 1'b1;
        fin_res.run_tag      = r_best.tag;
        fin_res.run_priority = r_best.prio;
        fin_res.run_elapsed  = el_next;
        fin_res.finished     = fin_now;
        fin_res.table_empty  = (cnt_after == '0);
        fin_res.occupancy    = OCC_W'(cnt_after);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_req_valid) n_state = S_EXEC;
            S_EXEC: begin
                if (r_req.op == OP_TICK && r_count != '0) n_state = S_SCAN;
                else n_state = S_DONE;
            end
            S_SCAN:  if (r_state == S_SCAN && scan_last) n_state = S_SHIFT;
            S_SHIFT: if (shift_done) n_state = S_FIN;
            S_FIN:   n_state = S_DONE;
            S_DONE:  if (i_res_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        o_we        = 1'b0;
        o_waddr     = r_count[AW-1:0];
        o_wdata     = i_rdata;
        o_raddr     = r_idx[AW-1:0];
        case (r_state)
            S_IDLE: o_req_ready = 1'b1;
            S_EXEC: begin
                o_wdata.tag     = r_req.tag;
                o_wdata.prio    = {{(PRIO_W-8){r_req.prio[7]}}, r_req.prio};
                o_wdata.need    = r_req.need;
                o_wdata.elapsed = '0;
                o_we = (r_req.op == OP_ADD) && (r_count < CNT_MAX);
            end
            S_SHIFT: begin
                // entry arriving from position k+1 lands at k
                o_we = r_rvalid;
                o_waddr = AW'(r_ridx - 1'b1);
            end
            S_FIN: begin
                o_we = !fin_now;
                o_waddr = AW'(r_count - 1'b1);
                o_wdata = r_best;
                o_wdata.prio    = prio_next;
                o_wdata.elapsed = el_next;
            end
            S_DONE: o_res_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rvalid <= ((r_state == S_SCAN) || (r_state == S_SHIFT)) && (r_idx < r_count);
            r_ridx   <= r_idx;
            case (r_state)
                S_IDLE: if (i_req_valid) r_req <= i_req;
                S_EXEC: begin
                    r_res <= exec_res;
                    r_idx <= '0;
                    if ((r_req.op == OP_ADD) && (r_count < CNT_MAX)) r_count <= cnt_add;
                end
                S_SCAN: begin
                    if (take) begin
                        r_best     <= i_rdata;
                        r_best_pos <= r_ridx;
                    end
                    if (scan_last) begin
                        r_idx <= pos_sel + 1'b1;
                    end else if (r_idx < r_count) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SHIFT: if (r_idx < r_count) r_idx <= r_idx + 1'b1;
                S_FIN: begin
                    r_count <= cnt_after;
                    r_res   <= fin_res;
                end
                default: ;
            endcase
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

FILE: rtl/dynamic_priority_process_scheduler_core.sv
// Highest-priority-first process scheduler with aging, stream in / stream out.
//
// Input requests arrive on s_axis: tuser selects the operation (0 add, 1 tick),
// tdata carries the tag, start priority and needed time of an added process.
// Every request yields exactly one result on m_axis.
// A tick on a table of N entries makes one pass of the shared priority comparator
// over the table memory (one entry read per cycle), then a compaction pass that
// moves every entry behind the dispatched one down by one place (one read and one
// write per cycle on the single-port-pair memory), then the re-append of the
// dispatched entry unless it has finished.
// s_axis_tready is high only while the sequencer is idle; one result may wait
// in the output register while the next request is accepted and worked on.
// If m_axis stalls, the sequencer holds its finished result until the output
// register frees up. Reset (synchronous, active low) empties the table and
// drops any pending result; table memory contents need no clearing.
// Depends on dpps_pkg, dpps_ctrl and dpps_ram.
`default_nettype none

module dynamic_priority_process_scheduler_core
    import dpps_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output      logic                  s_axis_tready,
    // [7:0] process_tag, [15:8] start_priority, [23:16] needed_time
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] operation
    input  wire logic                  s_axis_tuser,
    output      logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [0] accepted, [8:1] run_tag, [18:9] run_priority, [26:19] run_elapsed,
    // [27] finished, [28] table_empty, [33:29] occupancy, [39:34] zero
    output      logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int AW = $clog2(MAX_ENTRIES);

    t_request          req;
    t_result           res;
    logic              res_valid;
    logic              res_ready;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    t_entry            wdata;
    t_entry            rdata;
    logic [$bits(t_entry)-1:0] rdata_bits;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    assign req.op   = t_op'(s_axis_tuser);
    assign req.tag  = s_axis_tdata[7:0];
    assign req.prio = s_axis_tdata[15:8];
    assign req.need = s_axis_tdata[23:16];

    dpps_ctrl #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(s_axis_tvalid),
        .i_req      (req),
        .o_req_ready(s_axis_tready),
        .o_res_valid(res_valid),
        .o_res      (res),
        .i_res_ready(res_ready),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_raddr    (raddr),
        .i_rdata    (rdata)
    );

    dpps_ram #(
        .WIDTH($bits(t_entry)),
        .DEPTH(MAX_ENTRIES)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata_bits)
    );

    assign rdata = t_entry'(rdata_bits);

    // output register: loads whenever it is empty or being drained
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                r_out_valid <= 1'b1;
                r_out_data  <= {{(OUT_DATA_W-$bits(t_result)){1'b0}}, res};
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

FILE: tb/dynamic_priority_process_scheduler_core_test.sv
// Self-checking testbench for dynamic_priority_process_scheduler_core: directed table,
// then random add/tick phases under random stalls, checked against an in-bench scheduler.
// Depends on dpps_pkg and the scheduler RTL.
module dynamic_priority_process_scheduler_core_test;
    import dpps_pkg::*;

    localparam int TABLE_DEPTH   = 16;
    localparam int RANDOM_ITEMS  = 1650;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 60;

    typedef struct {
        t_op               op;
        logic [TAG_W-1:0]  tag;
        logic signed [7:0] prio;
        logic [TIME_W-1:0] need;
        bit                typed;
        t_result           want;
    } t_vector;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    t_entry  ready_list[$];
    t_result due_results[$];
    t_vector plan[$];
    int      mismatch_count = 0;
    int      idle_cycles = 0;
    int      rx_hold = 0;
    bit      tx_steady = 1'b0;
    bit      rx_steady = 1'b0;

    dynamic_priority_process_scheduler_core #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_result make_result(bit acc, int tag, int prio, int el, bit fin,
                                            bit empty, int occ);
        t_result r;
        r.accepted     = acc;
        r.run_tag      = TAG_W'(tag);
        r.run_priority = PRIO_W'(prio);
        r.run_elapsed  = TIME_W'(el);
        r.finished     = fin;
        r.table_empty  = empty;
        r.occupancy    = OCC_W'(occ);
        return r;
    endfunction

    function automatic void plan_row(t_op op, int tag, int prio, int need, bit typed,
                                     t_result want);
        t_vector v;
        v.op    = op;
        v.tag   = TAG_W'(tag);
        v.prio  = 8'(prio);
        v.need  = TIME_W'(need);
        v.typed = typed;
        v.want  = want;
        plan.push_back(v);
    endfunction

    // Applies one request to the ready list and returns the result it should produce.
    function automatic t_result dispatch_outcome(t_request rq);
        t_result r;
        t_entry  e;
        int      best;
        r = '0;
        if (rq.op == OP_ADD) begin
            if (ready_list.size() < TABLE_DEPTH) begin
                e.tag     = rq.tag;
                e.prio    = rq.prio;
                e.need    = rq.need;
                e.elapsed = '0;
                ready_list.push_back(e);
                r.accepted = 1'b1;
            end
        end else if (ready_list.size() > 0) begin
            // first of equal maxima wins
            best = 0;
            for (int k = 1; k < ready_list.size(); k++) begin
                if (ready_list[k].prio > ready_list[best].prio) best = k;
            end
            e = ready_list[best];
            ready_list.delete(best);
            e.elapsed      = e.elapsed + 1'b1;
            r.accepted     = 1'b1;
            r.run_tag      = e.tag;
            r.run_priority = e.prio;
            r.run_elapsed  = e.elapsed;
            if (e.elapsed >= e.need) begin
                r.finished = 1'b1;
            end else begin
                if (e.prio != PRIO_MIN) e.prio = e.prio - 1'b1;
                ready_list.push_back(e);
            end
        end
        r.table_empty = (ready_list.size() == 0);
        r.occupancy   = OCC_W'(ready_list.size());
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(t_request rq, bit typed, t_result want);
        t_result pred;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rq.need, rq.prio, rq.tag};
        s_axis_tuser  <= rq.op;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = dispatch_outcome(rq);
        due_results.push_back(typed ? want : pred);
        @(negedge i_clk);
    endtask

    task automatic sender_gap();
        int roll;
        int n;
        roll = $urandom_range(0, 99);
        n = 0;
        if (!tx_steady) begin
            if (roll >= 90) n = $urandom_range(10, 40);
            else if (roll >= 55) n = $urandom_range(1, 3);
        end
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // Result sink: short stalls mostly, an occasional long one.
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (!rx_steady && $urandom_range(0, 5) == 0) begin
                rx_hold = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 3);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[$bits(t_result)-1:0];
            if (due_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: tdata=%h", m_axis_tdata);
            end else begin
                want = due_results.pop_front();
                if (got.accepted !== want.accepted || got.run_tag !== want.run_tag ||
                    got.run_priority !== want.run_priority ||
                    got.run_elapsed !== want.run_elapsed ||
                    got.finished !== want.finished || got.table_empty !== want.table_empty ||
                    got.occupancy !== want.occupancy) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("result mismatch: exp acc=%0d tag=%0d prio=%0d el=%0d",
                                 want.accepted, want.run_tag, $signed(want.run_priority),
                                 want.run_elapsed);
                        $display("                 exp fin=%0d empty=%0d occ=%0d",
                                 want.finished, want.table_empty, want.occupancy);
                        $display("                 got acc=%0d tag=%0d prio=%0d el=%0d",
                                 got.accepted, got.run_tag, $signed(got.run_priority),
                                 got.run_elapsed);
                        $display("                 got fin=%0d empty=%0d occ=%0d",
                                 got.finished, got.table_empty, got.occupancy);
                    end
                end
            end
        end
    end

    // Watchdog: no request or result moving for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("dynamic_priority_process_scheduler_core: mismatch");
            $finish;
        end
    end

    initial begin
        t_request rq;
        int       sent_random;
        int       phase;
        int       span;
        int       add_pct;
        int       prio_mode;
        int       roll;

        // idle tick, extremes, need-zero retire, fill and refuse
        plan_row(OP_TICK, 'hC3, -1, 'h80, 1'b1, make_result(0, 0, 0, 0, 0, 1, 0));
        plan_row(OP_ADD, 'h00, -128, 1, 1'b1, make_result(1, 0, 0, 0, 0, 0, 1));
        plan_row(OP_ADD, 'hFF, 127, 255, 1'b1, make_result(1, 0, 0, 0, 0, 0, 2));
        plan_row(OP_TICK, 'h3C, 85, 'h7F, 1'b1, make_result(1, 'hFF, 127, 1, 0, 0, 2));
        plan_row(OP_TICK, 'hFF, 127, 'hFF, 1'b0, '0);
        plan_row(OP_ADD, 'h5A, 126, 0, 1'b0, '0);
        plan_row(OP_TICK, 'h00, 0, 0, 1'b0, '0);
        plan_row(OP_TICK, 'hA5, -86, 'h01, 1'b0, '0);
        for (int t = 1; t <= 14; t++) plan_row(OP_ADD, t, 0, 2, 1'b0, '0);
        plan_row(OP_ADD, 'hAA, 5, 3, 1'b1, make_result(0, 0, 0, 0, 0, 0, 16));
        plan_row(OP_TICK, 'h11, 0, 0, 1'b0, '0);
        plan_row(OP_TICK, 'h22, 0, 0, 1'b0, '0);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) begin
            rq.op   = plan[i].op;
            rq.tag  = plan[i].tag;
            rq.prio = plan[i].prio;
            rq.need = plan[i].need;
            send_request(rq, plan[i].typed, plan[i].want);
            sender_gap();
        end

        sent_random = 0;
        phase = 0;
        while (sent_random < RANDOM_ITEMS) begin
            span = $urandom_range(40, 160);
            case ($urandom_range(0, 2))
                0: add_pct = 75;
                1: add_pct = 25;
                default: add_pct = 50;
            endcase
            prio_mode = $urandom_range(0, 3);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            if (phase == 0 || $urandom_range(0, 3) == 0) begin
                // hold off until every outstanding request has its result
                if (due_results.size() != 0) begin
                    s_axis_tvalid <= 1'b0;
                    while (due_results.size() != 0) @(negedge i_clk);
                end
            end
            for (int k = 0; k < span && sent_random < RANDOM_ITEMS; k++) begin
                rq.op  = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_TICK;
                rq.tag = TAG_W'($urandom_range(0, 255));
                case (prio_mode)
                    1: rq.prio = 8'($urandom_range(0, 4) - 2);
                    2: begin
                        case ($urandom_range(0, 3))
                            0: rq.prio = -8'sd128;
                            1: rq.prio = 8'sd127;
                            2: rq.prio = -8'sd127;
                            default: rq.prio = 8'sd126;
                        endcase
                    end
                    default: rq.prio = 8'($urandom_range(0, 255));
                endcase
                roll = $urandom_range(0, 99);
                if (roll < 80) rq.need = TIME_W'($urandom_range(1, 6));
                else if (roll < 95) rq.need = TIME_W'($urandom_range(7, 40));
                else rq.need = TIME_W'($urandom_range(1, 255));
                send_request(rq, 1'b0, '0);
                sent_random++;
                sender_gap();
            end
            phase++;
        end

        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("dynamic_priority_process_scheduler_core: match");
        else
            $display("dynamic_priority_process_scheduler_core: mismatch");
        $finish;
    end

endmodule

FILE: dynamic_priority_process_scheduler_core.f
rtl/dpps_pkg.sv
rtl/dpps_ram.sv
rtl/dpps_ctrl.sv
rtl/dynamic_priority_process_scheduler_core.sv
tb/dynamic_priority_process_scheduler_core_test.sv
